// ===== sv/sts_pkg.sv =====
// shared types, codes and default table contents for the segment table sequencer
// no dependencies; imported by every module of the block
package sts_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int ADDR_W     = 4;
  localparam int ADDR_ROW_W = ADDR_W - 1;
  localparam int ADDR_ROWS  = 2 ** ADDR_ROW_W;
  localparam int WORD_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DEFAULT_ROWS = 5;

  // input word kinds
  localparam logic [2:0] KIND_CMD    = 3'd0;
  localparam logic [2:0] KIND_SAMPLE = 3'd1;
  localparam logic [2:0] KIND_MS     = 3'd2;
  localparam logic [2:0] KIND_WRITE  = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  // commands
  localparam logic [2:0] CMD_FORWARD = 3'd0;
  localparam logic [2:0] CMD_REWIND  = 3'd1;
  localparam logic [2:0] CMD_PLAY    = 3'd2;
  localparam logic [2:0] CMD_HALT    = 3'd3;
  localparam logic [2:0] CMD_REPLAY  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FWD_DUR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REW_DUR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REW_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_DUR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REP_TOTAL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REP_INTVL  = 3'd6;

  typedef struct packed {
    logic [15:0] forward_duration;
    logic [14:0] forward_level;
    logic [15:0] rewind_duration;
    logic [14:0] rewind_level;
    logic [15:0] settle_duration;
    logic [7:0]  repeat_total;
    logic [31:0] repeat_interval;
  } cfg_t;

  // sequencer to table storage
  typedef struct packed {
    logic                  prog_we;
    logic                  prog_sel_dur;
    logic [ADDR_ROW_W-1:0] prog_row;
    logic [WORD_W-1:0]     prog_wdata;
    logic                  copy;
    logic                  build;
    logic [WORD_W-1:0]     step_dur;
    logic [WORD_W-1:0]     step_level;
    logic [WORD_W-1:0]     settle_dur;
  } tab_ctrl_t;

  typedef struct packed {
    logic signed [15:0] drive_level;
    logic               running;
    logic [15:0]        read_data;
    logic [7:0]         repeats_pending;
  } res_t;

  // only the address-reachable rows can ever hold nonzero words
  function automatic int play_rows(input int n);
    return (n < ADDR_ROWS) ? n : ADDR_ROWS;
  endfunction

  function automatic logic [WORD_W-1:0] default_level(input int i);
    case (i)
      0:       return 16'hFC18;
      1:       return 16'd100;
      3:       return 16'hFED4;
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] default_duration(input int i);
    case (i)
      0, 1, 3, 4: return 16'd150;
      2:          return 16'd200;
      default:    return 16'd0;
    endcase
  endfunction

endpackage

// ===== sv/sts_table.sv =====
// programmable and play segment tables held in flip-flops
// depends on sts_pkg; written under control of sts_seq
module sts_table import sts_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  tab_ctrl_t                              ctrl,
  input  logic [$clog2(play_rows(TABLE_ENTRIES)+1)-1:0] play_index,
  output logic [WORD_W-1:0]                      read_word,
  output logic [WORD_W-1:0]                      play_level,
  output logic [WORD_W-1:0]                      play_dur
);

  localparam int ROWS  = play_rows(TABLE_ENTRIES);
  localparam int ROW_W = $clog2(ROWS);
  localparam int IDX_W = $clog2(ROWS + 1);

  logic [WORD_W-1:0] prog_levels    [ROWS];
  logic [WORD_W-1:0] prog_durations [ROWS];
  logic [WORD_W-1:0] play_levels    [ROWS];
  logic [WORD_W-1:0] play_durations [ROWS];

  logic row_ok;
  logic idx_ok;

  assign row_ok = {1'b0, ctrl.prog_row} < (ADDR_ROW_W + 1)'(ROWS);
  assign idx_ok = play_index < IDX_W'(ROWS);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) begin
        prog_levels[i]    <= default_level(i);
        prog_durations[i] <= default_duration(i);
        play_levels[i]    <= '0;
        play_durations[i] <= '0;
      end
    end else begin
      if (ctrl.prog_we && row_ok) begin
        if (ctrl.prog_sel_dur) begin
          prog_durations[ctrl.prog_row[ROW_W-1:0]] <= ctrl.prog_wdata;
        end else begin
          prog_levels[ctrl.prog_row[ROW_W-1:0]] <= ctrl.prog_wdata;
        end
      end
      if (ctrl.copy) begin
        for (int i = 0; i < ROWS; i++) begin
          play_levels[i]    <= prog_levels[i];
          play_durations[i] <= prog_durations[i];
        end
      end else if (ctrl.build) begin
        for (int i = 2; i < ROWS; i++) begin
          play_levels[i]    <= '0;
          play_durations[i] <= '0;
        end
        play_levels[0]    <= ctrl.step_level;
        play_durations[0] <= ctrl.step_dur;
        play_levels[1]    <= '0;
        play_durations[1] <= ctrl.settle_dur;
      end
    end
  end

  always_comb begin
    read_word = '0;
    if (row_ok) begin
      read_word = ctrl.prog_sel_dur ? prog_durations[ctrl.prog_row[ROW_W-1:0]]
                                    : prog_levels[ctrl.prog_row[ROW_W-1:0]];
    end
    play_level = idx_ok ? play_levels[play_index[ROW_W-1:0]] : '0;
    play_dur   = idx_ok ? play_durations[play_index[ROW_W-1:0]] : '0;
  end

endmodule

// ===== sv/sts_seq.sv =====
// playback and replay sequencing state, result word formation
// depends on sts_pkg; drives sts_table through tab_ctrl_t
module sts_seq import sts_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   fire,
  input  logic [2:0]                             kind,
  input  logic [2:0]                             command,
  input  logic [ADDR_W-1:0]                      table_address,
  input  logic [WORD_W-1:0]                      write_data,
  input  cfg_t                                   cfg,
  input  logic [WORD_W-1:0]                      read_word,
  input  logic [WORD_W-1:0]                      play_level,
  input  logic [WORD_W-1:0]                      play_dur,
  output logic [$clog2(play_rows(TABLE_ENTRIES)+1)-1:0] play_index,
  output tab_ctrl_t                              ctrl,
  output res_t                                   res
);

  localparam int ROWS  = play_rows(TABLE_ENTRIES);
  localparam int IDX_W = $clog2(ROWS + 1);

  logic [IDX_W-1:0]  segment_index, segment_index_next;
  logic [15:0]       ticks_left, ticks_left_next;
  logic [15:0]       held_level, held_level_next;
  logic              playing, playing_next;
  logic [7:0]        replays_left, replays_left_next;
  logic [31:0]       replay_timer, replay_timer_next;
  logic [31:0]       timer_dec;
  logic              idle;

  assign play_index = segment_index;
  assign idle       = !playing && (replays_left == 8'd0);
  assign timer_dec  = (replay_timer != 32'd0) ? replay_timer - 32'd1 : 32'd0;

  always_comb begin
    segment_index_next = segment_index;
    ticks_left_next    = ticks_left;
    held_level_next    = held_level;
    playing_next       = playing;
    replays_left_next  = replays_left;
    replay_timer_next  = replay_timer;

    ctrl              = '0;
    ctrl.prog_sel_dur = table_address[0];
    ctrl.prog_row     = table_address[ADDR_W-1:1];
    ctrl.prog_wdata   = write_data;
    ctrl.settle_dur   = cfg.settle_duration;

    res             = '0;

    if (fire) begin
      case (kind)
        KIND_CMD: begin
          case (command)
            CMD_FORWARD, CMD_REWIND: begin
              if (idle) begin
                ctrl.build = 1'b1;
                if (command == CMD_FORWARD) begin
                  ctrl.step_dur   = cfg.forward_duration;
                  ctrl.step_level = {1'b0, cfg.forward_level};
                end else begin
                  ctrl.step_dur   = cfg.rewind_duration;
                  ctrl.step_level = 16'd0 - {1'b0, cfg.rewind_level};
                end
                segment_index_next = '0;
                ticks_left_next    = '0;
                playing_next       = 1'b1;
              end
            end
            CMD_PLAY: begin
              if (!playing) begin
                ctrl.copy          = 1'b1;
                segment_index_next = '0;
                ticks_left_next    = '0;
                playing_next       = 1'b1;
              end
            end
            CMD_HALT: begin
              playing_next      = 1'b0;
              replays_left_next = '0;
              replay_timer_next = '0;
            end
            CMD_REPLAY: begin
              if (idle) begin
                replays_left_next = cfg.repeat_total;
                replay_timer_next = '0;
              end
            end
            default: ;
          endcase
        end
        KIND_SAMPLE: begin
          if (playing) begin
            if (ticks_left != 16'd0) begin
              ticks_left_next = ticks_left - 16'd1;
              res.drive_level = held_level;
            end else if (segment_index >= IDX_W'(ROWS) || play_dur == 16'd0) begin
              playing_next = 1'b0;
            end else begin
              ticks_left_next    = play_dur;
              held_level_next    = play_level;
              segment_index_next = segment_index + IDX_W'(1);
              res.drive_level    = play_level;
            end
          end
        end
        KIND_MS: begin
          replay_timer_next = timer_dec;
          // a due replay is consumed even when playback is already busy
          if (replays_left != 8'd0 && timer_dec == 32'd0) begin
            replays_left_next = replays_left - 8'd1;
            replay_timer_next = cfg.repeat_interval;
            if (!playing) begin
              ctrl.copy          = 1'b1;
              segment_index_next = '0;
              ticks_left_next    = '0;
              playing_next       = 1'b1;
            end
          end
        end
        KIND_WRITE: ctrl.prog_we = 1'b1;
        KIND_READ:  res.read_data = read_word;
        default: ;
      endcase
    end

    res.running         = playing_next;
    res.repeats_pending = replays_left_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_index <= '0;
      ticks_left    <= '0;
      held_level    <= '0;
      playing       <= 1'b0;
      replays_left  <= '0;
      replay_timer  <= '0;
    end else begin
      segment_index <= segment_index_next;
      ticks_left    <= ticks_left_next;
      held_level    <= held_level_next;
      playing       <= playing_next;
      replays_left  <= replays_left_next;
      replay_timer  <= replay_timer_next;
    end
  end

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    fire && kind == KIND_CMD && command == CMD_HALT |=> !playing && replays_left == 8'd0)
    else $error("stop did not clear playback and replays");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    segment_index <= IDX_W'(ROWS))
    else $error("segment index past table end");

  a_drive_only_on_sample: assert property (@(posedge clk) disable iff (rst)
    !(fire && kind == KIND_SAMPLE) |-> res.drive_level == 16'sd0)
    else $error("drive level on a word that is not a sample tick");

endmodule

// ===== sv/segment_table_drive_sequencer_unit.sv =====
// segment table drive sequencer: input register, sequencer, table storage, output register
// depends on sts_pkg, sts_seq, sts_table
// an accepted word is held in the input register; on firing its result word is registered
// throughput: one word per cycle while the output is not stalled; the single-pass state update sets the rate
// input stalls only while the output register holds a word that is being stalled
// reset: synchronous, loads the default programmable table, clears play table and state
module segment_table_drive_sequencer_unit import sts_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            kind,
  input  logic [2:0]            command,
  input  logic [ADDR_W-1:0]     table_address,
  input  logic [WORD_W-1:0]     write_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    drive_level,
  output logic                  running,
  output logic [15:0]           read_data,
  output logic [7:0]            repeats_pending,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(play_rows(TABLE_ENTRIES) + 1);

  cfg_t              cfg;
  logic              s1_valid;
  logic [2:0]        s1_kind;
  logic [2:0]        s1_command;
  logic [ADDR_W-1:0] s1_address;
  logic [WORD_W-1:0] s1_wdata;
  logic              s1_fire;
  logic              in_take;
  tab_ctrl_t         ctrl;
  res_t              res;
  logic [IDX_W-1:0]  play_index;
  logic [WORD_W-1:0] read_word;
  logic [WORD_W-1:0] play_level;
  logic [WORD_W-1:0] play_dur;

  assign s1_fire  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_fire;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FWD_DUR:    cfg.forward_duration <= cfg_data[15:0];
        REG_FWD_LEVEL:  cfg.forward_level    <= cfg_data[14:0];
        REG_REW_DUR:    cfg.rewind_duration  <= cfg_data[15:0];
        REG_REW_LEVEL:  cfg.rewind_level     <= cfg_data[14:0];
        REG_SETTLE_DUR: cfg.settle_duration  <= cfg_data[15:0];
        REG_REP_TOTAL:  cfg.repeat_total     <= cfg_data[7:0];
        REG_REP_INTVL:  cfg.repeat_interval  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind    <= kind;
      s1_command <= command;
      s1_address <= table_address;
      s1_wdata   <= write_data;
    end
  end

  sts_seq #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_seq (
    .clk           (clk),
    .rst           (rst),
    .fire          (s1_fire),
    .kind          (s1_kind),
    .command       (s1_command),
    .table_address (s1_address),
    .write_data    (s1_wdata),
    .cfg           (cfg),
    .read_word     (read_word),
    .play_level    (play_level),
    .play_dur      (play_dur),
    .play_index    (play_index),
    .ctrl          (ctrl),
    .res           (res)
  );

  sts_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .play_index (play_index),
    .read_word  (read_word),
    .play_level (play_level),
    .play_dur   (play_dur)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      drive_level     <= res.drive_level;
      running         <= res.running;
      read_data       <= res.read_data;
      repeats_pending <= res.repeats_pending;
    end
  end

endmodule
